@@ src/kfpi_pkg.sv @@
// Package for the keyframe pose interpolator: widths, command codes,
// sequencer states and the divider control struct. No dependencies.
`default_nettype none
package kfpi_pkg;
    localparam int FRAME_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int FA_W        = $clog2(FRAME_DEPTH);
    localparam int FC_W        = $clog2(FRAME_DEPTH + 1);
    localparam int NUM_CH      = 6;
    localparam int NUM_ANIM    = 5;
    localparam logic [31:0] QUARTER = 32'(1) << (FRAC_BITS - 2);
    localparam logic [7:0]  STEP_RESET = 8'd50;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_PLAY  = 3'd1;
    localparam logic [2:0] CMD_SAVE  = 3'd2;
    localparam logic [2:0] CMD_REARM = 3'd3;
    localparam logic [2:0] CMD_NUDGE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAVE,
        ST_RDA,
        ST_RDB,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ src/kfpi_div.sv @@
// Shared serial signed divider: 33-bit dividend by 8-bit unsigned divisor,
// one quotient bit per cycle, truncating toward zero. Uses kfpi_pkg.
`default_nettype none
module kfpi_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kfpi_pkg::t_div_req i_req,
    output kfpi_pkg::t_div_rsp      o_rsp
);
    logic [32:0] r_quo, n_quo;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_dvs, n_dvs;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] mag;
    logic [8:0]  trial;
    logic [32:0] qs;

    always_comb begin
        mag    = i_req.dividend[32] ? (33'd0 - i_req.dividend) : i_req.dividend;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem[7:0], r_quo[32]};
        if (i_req.start) begin
            n_quo  = mag;
            n_rem  = 9'd0;
            n_dvs  = (i_req.divisor == 8'd0) ? 8'd1 : i_req.divisor;
            n_neg  = i_req.dividend[32];
            n_cnt  = 6'd33;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial - {1'b0, r_dvs};
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign qs = r_neg ? (33'd0 - r_quo) : r_quo;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = qs[31:0];
endmodule
`default_nettype wire

@@ src/keyframe_pose_interpolator.sv @@
// Top level of the keyframe pose interpolator: pose registers, keyframe
// memory, sequencer. Uses kfpi_pkg and kfpi_div.
//
// Usage: one input beat carries a command (tick, start/stop, save, rearm,
// nudge) with axis and direction. Each accepted beat yields exactly one
// output beat holding the updated pose and status.
// Input stall is high while an item is in work or its result waits.
// Plain commands go from idle straight to the output register; a save
// passes through the save state first. A start, or a tick that moves on
// to a next segment, reads two frames from the keyframe memory and runs
// five serial divisions on one shared divider.
// The result is held on the output ports while i_out_stall is high and
// the next item is taken only after the beat leaves.
// Reset (synchronous, active low) clears the pose, increments, counters
// and flags and sets step_count to 50; the keyframe memory is not cleared.
// Write step_count via i_cfg_we/i_cfg_data only while idle; not checked.
`default_nettype none
module keyframe_pose_interpolator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [2:0]  i_axis,
    input  wire logic        i_direction,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_rot_x,
    output logic signed [31:0] o_rot_y,
    output logic signed [31:0] o_rot_z,
    output logic             o_playing,
    output logic [5:0]       o_segment,
    output logic [6:0]       o_frames_saved,
    output logic             o_save_armed
);
    localparam int FA = kfpi_pkg::FA_W;
    localparam int FC = kfpi_pkg::FC_W;

    kfpi_pkg::t_state r_state, n_state;
    logic [31:0] r_pose [kfpi_pkg::NUM_CH];
    logic [31:0] r_inc  [kfpi_pkg::NUM_ANIM];
    logic [191:0] r_mem [kfpi_pkg::FRAME_DEPTH];
    logic [191:0] r_rd, r_fa;
    logic [FC-1:0] r_fcnt;
    logic [FA-1:0] r_seg;
    logic [7:0]  r_tick, r_step;
    logic        r_play, r_lock;
    logic [2:0]  r_ch;
    logic [FA-1:0] rd_addr;
    logic        in_acc, out_acc;
    kfpi_pkg::t_div_req div_req;
    kfpi_pkg::t_div_rsp div_rsp;
    logic [31:0] fa_c, fb_c;
    logic [FC-1:0] seg_next;

    assign in_acc  = i_in_valid && (r_state == kfpi_pkg::ST_IDLE);
    assign out_acc = (r_state == kfpi_pkg::ST_OUT) && !i_out_stall;
    assign seg_next = FC'(r_seg) + FC'(1);

    always_comb begin
        case (r_ch)
            3'd0:    begin fa_c = r_fa[31:0];    fb_c = r_rd[31:0];    end
            3'd1:    begin fa_c = r_fa[63:32];   fb_c = r_rd[63:32];   end
            3'd2:    begin fa_c = r_fa[95:64];   fb_c = r_rd[95:64];   end
            3'd3:    begin fa_c = r_fa[127:96];  fb_c = r_rd[127:96];  end
            default: begin fa_c = r_fa[159:128]; fb_c = r_rd[159:128]; end
        endcase
        div_req.start    = (r_state == kfpi_pkg::ST_DIV_GO);
        div_req.dividend = {fb_c[31], fb_c} - {fa_c[31], fa_c};
        div_req.divisor  = r_step;
    end

    kfpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kfpi_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = kfpi_pkg::ST_OUT;
                    if (i_command == kfpi_pkg::CMD_SAVE && !r_lock
                        && r_fcnt < FC'(kfpi_pkg::FRAME_DEPTH))
                        n_state = kfpi_pkg::ST_SAVE;
                    if (i_command == kfpi_pkg::CMD_PLAY && !r_play && r_fcnt > FC'(1))
                        n_state = kfpi_pkg::ST_RDA;
                    if (i_command == kfpi_pkg::CMD_TICK && r_play && r_tick >= r_step
                        && seg_next + FC'(1) < r_fcnt)
                        n_state = kfpi_pkg::ST_RDA;
                end
            end
            kfpi_pkg::ST_SAVE:     n_state = kfpi_pkg::ST_OUT;
            kfpi_pkg::ST_RDA:      n_state = kfpi_pkg::ST_RDB;
            kfpi_pkg::ST_RDB:      n_state = kfpi_pkg::ST_DIV_GO;
            kfpi_pkg::ST_DIV_GO:   n_state = kfpi_pkg::ST_DIV_WAIT;
            kfpi_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done)
                    n_state = (r_ch == 3'd4) ? kfpi_pkg::ST_OUT : kfpi_pkg::ST_DIV_GO;
            end
            kfpi_pkg::ST_OUT:      if (out_acc) n_state = kfpi_pkg::ST_IDLE;
            default:               n_state = kfpi_pkg::ST_IDLE;
        endcase
    end

    // Read address: frame a in ST_RDA, frame a+1 in ST_RDB.
    always_comb begin
        rd_addr = (r_state == kfpi_pkg::ST_RDB) ? r_seg + FA'(1) : r_seg;
    end

    // The read register keeps frame a+1 through all five divisions.
    always_ff @(posedge i_clk) begin
        if (r_state == kfpi_pkg::ST_RDA || r_state == kfpi_pkg::ST_RDB)
            r_rd <= r_mem[rd_addr];
        if (r_state == kfpi_pkg::ST_SAVE)
            r_mem[r_fcnt[FA-1:0]] <= {r_pose[5], r_pose[4], r_pose[3],
                                      r_pose[2], r_pose[1], r_pose[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfpi_pkg::ST_IDLE;
            for (int c = 0; c < kfpi_pkg::NUM_CH; c++) r_pose[c] <= 32'd0;
            for (int c = 0; c < kfpi_pkg::NUM_ANIM; c++) r_inc[c] <= 32'd0;
            r_fcnt <= '0;
            r_seg  <= '0;
            r_tick <= 8'd0;
            r_play <= 1'b0;
            r_lock <= 1'b0;
            r_step <= kfpi_pkg::STEP_RESET;
            r_ch   <= 3'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_step <= i_cfg_data;
            if (in_acc) begin
                r_ch <= 3'd0;
                case (i_command)
                    kfpi_pkg::CMD_TICK: begin
                        if (r_play) begin
                            if (r_tick >= r_step) begin
                                if (seg_next + FC'(2) > r_fcnt) begin
                                    r_seg  <= '0;
                                    r_play <= 1'b0;
                                end else begin
                                    r_seg  <= seg_next[FA-1:0];
                                    r_tick <= 8'd0;
                                end
                            end else begin
                                for (int c = 0; c < kfpi_pkg::NUM_ANIM; c++)
                                    r_pose[c] <= r_pose[c] + r_inc[c];
                                r_tick <= r_tick + 8'd1;
                            end
                        end
                    end
                    kfpi_pkg::CMD_PLAY: begin
                        if (!r_play && r_fcnt > FC'(1)) begin
                            r_play <= 1'b1;
                            r_seg  <= '0;
                            r_tick <= 8'd0;
                        end else begin
                            r_play <= 1'b0;
                        end
                    end
                    kfpi_pkg::CMD_REARM: r_lock <= 1'b0;
                    kfpi_pkg::CMD_NUDGE: begin
                        if (i_axis < 3'd6)
                            r_pose[i_axis] <= i_direction ? r_pose[i_axis] - kfpi_pkg::QUARTER
                                                          : r_pose[i_axis] + kfpi_pkg::QUARTER;
                    end
                    default: ;
                endcase
            end
            if (r_state == kfpi_pkg::ST_SAVE) begin
                r_fcnt <= r_fcnt + FC'(1);
                r_lock <= 1'b1;
            end
            if (r_state == kfpi_pkg::ST_RDB) begin
                r_fa <= r_rd;
                // A start loads the five animated channels from frame 0.
                if (r_tick == 8'd0 && r_seg == '0 && r_play)
                    for (int c = 0; c < kfpi_pkg::NUM_ANIM; c++)
                        r_pose[c] <= r_rd[c*32 +: 32];
            end
            if (r_state == kfpi_pkg::ST_DIV_WAIT && div_rsp.done) begin
                r_inc[r_ch] <= div_rsp.quotient;
                r_ch <= r_ch + 3'd1;
            end
        end
    end

    assign o_in_stall     = (r_state != kfpi_pkg::ST_IDLE);
    assign o_out_valid    = (r_state == kfpi_pkg::ST_OUT);
    assign o_pos_x        = r_pose[0];
    assign o_pos_y        = r_pose[1];
    assign o_pos_z        = r_pose[2];
    assign o_rot_x        = r_pose[3];
    assign o_rot_y        = r_pose[4];
    assign o_rot_z        = r_pose[5];
    assign o_playing      = r_play;
    assign o_segment      = 6'(r_seg);
    assign o_frames_saved = 7'(r_fcnt);
    assign o_save_armed   = !r_lock;
endmodule
`default_nettype wire
